// File: src/dct_pkg.sv
// Shared types, widths and matrix constants for the 8-point DCT-II transform.
package dct_pkg;

	localparam int VEC_LEN      = 8;
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 19;
	localparam int TABLE_FRAC   = 30;
	localparam int ANGLE_SPAN   = 4 * VEC_LEN;
	localparam int HALF_SPAN    = 2 * VEC_LEN;
	localparam int DC_ANGLE     = 4;

	// 0.5*cos(j*pi/16) in Q30, j = 0..8
	localparam int HALF_COS_Q30 [VEC_LEN+1] = '{
		536870912, 526555088, 496004047, 446391849, 379625062,
		298269498, 205451603, 104738319, 0
	};

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} stage_ctl_t;

	// Matrix entry T[n][k] rounded to frac fraction bits.
	function automatic int coef_entry(input int n, input int k, input int frac);
		int   a;
		logic neg;
		int   r;
		neg = 1'b0;
		if (k == 0) begin
			a = DC_ANGLE;
		end else begin
			a = ((2 * n + 1) * k) % ANGLE_SPAN;
			if (a > HALF_SPAN) begin
				a = ANGLE_SPAN - a;
			end
			if (a > VEC_LEN) begin
				a   = HALF_SPAN - a;
				neg = 1'b1;
			end
		end
		r = (HALF_COS_Q30[a] + (1 <<< (TABLE_FRAC - frac - 1))) >>> (TABLE_FRAC - frac);
		return neg ? -r : r;
	endfunction

endpackage

// File: src/dct_sample_if.sv
// Input channel: one word of eight Q3.12 samples.
interface dct_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_0;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_1;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_2;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_3;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_4;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_5;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_6;
	logic signed [dct_pkg::SAMPLE_W-1:0]    sample_7;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
		sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

// File: src/dct_coef_if.sv
// Output channel: one word of eight DCT coefficients.
interface dct_coef_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dct_pkg::COEF_W-1:0]    coef_0;
	logic signed [dct_pkg::COEF_W-1:0]    coef_1;
	logic signed [dct_pkg::COEF_W-1:0]    coef_2;
	logic signed [dct_pkg::COEF_W-1:0]    coef_3;
	logic signed [dct_pkg::COEF_W-1:0]    coef_4;
	logic signed [dct_pkg::COEF_W-1:0]    coef_5;
	logic signed [dct_pkg::COEF_W-1:0]    coef_6;
	logic signed [dct_pkg::COEF_W-1:0]    coef_7;

	modport source (output valid, coef_0, coef_1, coef_2, coef_3,
		coef_4, coef_5, coef_6, coef_7, input ready);
	modport sink (input valid, coef_0, coef_1, coef_2, coef_3,
		coef_4, coef_5, coef_6, coef_7, output ready);
endinterface

// File: src/dct_lane.sv
// One sample lane: multiplies a sample by its matrix row, products registered.
module dct_lane #(
	parameter int ROW            = 0,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                                  clk,
	input  dct_pkg::stage_ctl_t                                   ctl,
	input  logic signed [dct_pkg::SAMPLE_W-1:0]                   sample,
	output logic signed [dct_pkg::SAMPLE_W+COEF_FRAC_BITS:0]      prod_s1 [dct_pkg::VEC_LEN]
);

	localparam int CW = COEF_FRAC_BITS + 1;
	localparam int PW = dct_pkg::SAMPLE_W + CW;

	for (genvar k = 0; k < dct_pkg::VEC_LEN; k++) begin : g_col
		localparam logic signed [CW-1:0] ENT = CW'(dct_pkg::coef_entry(ROW, k, COEF_FRAC_BITS));
		logic signed [PW-1:0] prod_d;

		assign prod_d = PW'(sample) * PW'(ENT);

		always_ff @(posedge clk) begin
			if (ctl.en_s1) begin
				prod_s1[k] <= prod_d;
			end
		end
	end

endmodule

// File: src/dct_merge.sv
// Merging adder tree: sums lane products per coefficient and rounds to Q12.
module dct_merge #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                              clk,
	input  dct_pkg::stage_ctl_t                               ctl,
	input  logic signed [dct_pkg::SAMPLE_W+COEF_FRAC_BITS:0]  prod_s1 [dct_pkg::VEC_LEN][dct_pkg::VEC_LEN],
	output logic signed [dct_pkg::COEF_W-1:0]                 coef_s4 [dct_pkg::VEC_LEN]
);

	localparam int PW  = dct_pkg::SAMPLE_W + COEF_FRAC_BITS + 1;
	localparam int SW  = PW + 3;
	localparam int VL  = dct_pkg::VEC_LEN;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);

	for (genvar k = 0; k < VL; k++) begin : g_col
		logic signed [PW:0]   pair_s2 [VL/2];
		logic signed [PW+1:0] quad_s3 [VL/4];
		logic signed [SW-1:0] sum_d;

		always_ff @(posedge clk) begin
			if (ctl.en_s2) begin
				for (int i = 0; i < VL/2; i++) begin
					pair_s2[i] <= (PW+1)'(prod_s1[2*i][k]) + (PW+1)'(prod_s1[2*i+1][k]);
				end
			end
			if (ctl.en_s3) begin
				for (int j = 0; j < VL/4; j++) begin
					quad_s3[j] <= (PW+2)'(pair_s2[2*j]) + (PW+2)'(pair_s2[2*j+1]);
				end
			end
		end

		assign sum_d = SW'(quad_s3[0]) + SW'(quad_s3[1]) + HALF;

		always_ff @(posedge clk) begin
			if (ctl.en_s4) begin
				coef_s4[k] <= sum_d[COEF_FRAC_BITS+dct_pkg::COEF_W-1:COEF_FRAC_BITS];
			end
		end
	end

endmodule

// File: src/dct_ii_vector_transform.sv
// Top level of the 8-point orthonormal DCT-II: sample lanes plus merging adder tree.
// Four stages: input word -> prod_s1 -> pair_s2 -> quad_s3 -> coef_s4 -> result on dout.
// Throughput: one word per cycle while dout is ready; a stage moves when the next has room.
// Stall: only the output register blocks; interior bubbles are filled while dout waits.
// Reset clears the stage valid bits; no data registers are reset.
module dct_ii_vector_transform #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	dct_sample_if.sink          din,
	dct_coef_if.source          dout
);

	localparam int PW = dct_pkg::SAMPLE_W + COEF_FRAC_BITS + 1;
	localparam int VL = dct_pkg::VEC_LEN;

	dct_pkg::stage_ctl_t ctl;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [dct_pkg::SAMPLE_W-1:0] sample [VL];
	logic signed [PW-1:0]                prod_s1 [VL][VL];
	logic signed [dct_pkg::COEF_W-1:0]   coef_s4 [VL];

	assign ctl.en_s4 = !v_s4 || dout.ready;
	assign ctl.en_s3 = !v_s3 || ctl.en_s4;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign ctl.en_s1 = !v_s1 || ctl.en_s2;
	assign din.ready = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= din.valid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	assign sample[0] = din.sample_0;
	assign sample[1] = din.sample_1;
	assign sample[2] = din.sample_2;
	assign sample[3] = din.sample_3;
	assign sample[4] = din.sample_4;
	assign sample[5] = din.sample_5;
	assign sample[6] = din.sample_6;
	assign sample[7] = din.sample_7;

	for (genvar m = 0; m < VL; m++) begin : g_lane
		dct_lane #(
			.ROW            (m),
			.COEF_FRAC_BITS (COEF_FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.sample  (sample[m]),
			.prod_s1 (prod_s1[m])
		);
	end

	dct_merge #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.ctl     (ctl),
		.prod_s1 (prod_s1),
		.coef_s4 (coef_s4)
	);

	assign dout.valid  = v_s4;
	assign dout.coef_0 = coef_s4[0];
	assign dout.coef_1 = coef_s4[1];
	assign dout.coef_2 = coef_s4[2];
	assign dout.coef_3 = coef_s4[3];
	assign dout.coef_4 = coef_s4[4];
	assign dout.coef_5 = coef_s4[5];
	assign dout.coef_6 = coef_s4[6];
	assign dout.coef_7 = coef_s4[7];

	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		dout.ready |-> din.ready)
		else $error("input stalled while output drains");

	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> din.ready)
		else $error("input stalled with empty first stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> v_s1)
		else $error("accepted word lost at first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ctl.en_s3 |=> v_s3 && v_s4)
		else $error("stalled word dropped in adder tree");

endmodule
